[src/wct_pkg.sv]
// wct_pkg: sizes, field widths, codes and address helpers for the tile synthesizer.
// Used by wct_mod and wave_collapse_tile_synth; depends on nothing.
package wct_pkg;

  localparam int TILE     = 3;
  localparam int OUT_W    = 32;
  localparam int OUT_H    = 32;
  localparam int BASE_MAX = 16;

  localparam int PSIDE    = BASE_MAX - TILE + 1;
  localparam int NPAT_MAX = PSIDE * PSIDE;
  localparam int RES_W    = OUT_W + TILE - 1;
  localparam int RES_H    = OUT_H + TILE - 1;
  localparam int NCELL    = OUT_W * OUT_H;
  localparam int OUT_NPIX = RES_W * RES_H;
  localparam int BASE_N   = BASE_MAX * BASE_MAX;
  localparam int TT       = TILE * TILE;

  localparam int CLR_A    = (OUT_NPIX > NCELL) ? OUT_NPIX : NCELL;
  localparam int CLR_LEN  = (CLR_A > BASE_N) ? CLR_A : BASE_N + 1;

  localparam int CNT_W = $clog2(NPAT_MAX + 1);
  localparam int PC_W  = $clog2(PSIDE + 1);
  localparam int CR_W  = $clog2(OUT_H);
  localparam int CC_W  = $clog2(OUT_W);
  localparam int NR_W  = CR_W + 2;
  localparam int NC_W  = CC_W + 2;
  localparam int OA_W  = $clog2(OUT_NPIX);
  localparam int CA_W  = $clog2(NCELL);
  localparam int SC_W  = $clog2(NCELL + 1);
  localparam int BA_W  = $clog2(BASE_N);
  localparam int IDX_W = $clog2(CLR_LEN + 1);
  localparam int Q_W   = $clog2(TT + 1);
  localparam int WI_W  = $clog2(TT);
  localparam int T_W   = $clog2(TILE);
  localparam int D_W   = $clog2(2 * TILE - 1);
  localparam int RND_W = 31;
  localparam int DIM_W = 5;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                live;
    logic [CNT_W-1:0]    cnt;
    logic [NPAT_MAX-1:0] alive;
  } cell_t;

  function automatic logic [OA_W-1:0] out_addr(input int r, input int c);
    return OA_W'(r * RES_W + c);
  endfunction

  function automatic logic [CA_W-1:0] cell_addr(input int r, input int c);
    return CA_W'(r * OUT_W + c);
  endfunction

  function automatic logic [BA_W-1:0] base_addr(input int r, input int c);
    return BA_W'(r * BASE_MAX + c);
  endfunction

  function automatic logic [PC_W-1:0] pat_side(input logic [DIM_W-1:0] v);
    int d;
    d = int'(v);
    if (d < TILE) d = TILE;
    if (d > BASE_MAX) d = BASE_MAX;
    return PC_W'(d - (TILE - 1));
  endfunction

endpackage

[src/wct_ram.sv]
// wct_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wct_mod.sv]
// wct_mod: iterative remainder unit, one dividend bit per cycle (restoring).
// Depends on wct_pkg.
module wct_mod import wct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] rem
);

  localparam int K_W = $clog2(RND_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [K_W-1:0]   cnt_r;
  logic [RND_W-1:0] dvd_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;

  assign trial = {rem_r, dvd_r[RND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= K_W'(RND_W);
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= diff[CNT_W-1:0];
        end else begin
          rem_r <= trial[CNT_W-1:0];
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == K_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[src/wave_collapse_tile_synth.sv]
// Load, read and finished-step items go to S_RESP (reads in range pass S_RD first), which presents the result.
// Start: one sweep over the output, cell and base RAMs.
// Collapse step: picks a pattern for the chosen cell, writes its window, then updates up to 25 neighbor cells
// pattern by pattern and scans all NCELL cells, one RAM port each.
// Reset is synchronous; afterwards a clearing pass zeroes the output map
// while no item is taken. One item is worked on at a time.
module wave_collapse_tile_synth import wct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [5:0]       in_row,
  input  logic [5:0]       in_col,
  input  logic [7:0]       in_pixel,
  input  logic [30:0]      in_random,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_done_res,
  output logic [7:0]       out_pixel_out,
  output logic [4:0]       out_cell_row,
  output logic [4:0]       out_cell_col,
  output logic [7:0]       out_live_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RESP  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CCHK  = 4'd5;
  localparam logic [3:0] S_CDIV  = 4'd6;
  localparam logic [3:0] S_PICK  = 4'd7;
  localparam logic [3:0] S_WISS  = 4'd8;
  localparam logic [3:0] S_WEVAL = 4'd9;
  localparam logic [3:0] S_NSEL  = 4'd10;
  localparam logic [3:0] S_NRD   = 4'd11;
  localparam logic [3:0] S_NWIN  = 4'd12;
  localparam logic [3:0] S_NPAT  = 4'd13;
  localparam logic [3:0] S_NWB   = 4'd14;
  localparam logic [3:0] S_SRCH  = 4'd15;

  logic [3:0]          state_r;
  logic [IDX_W-1:0]    idx_r;
  logic                start_r;
  logic                fin_r;
  logic [CR_W-1:0]     cr_r;
  logic [CC_W-1:0]     cc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIM_W-1:0]    bw_r, bh_r;
  logic [PC_W-1:0]     pcols_r;
  logic [CNT_W-1:0]    ptot_r;
  logic [RND_W-1:0]    rnd_r;
  logic [7:0]          pix_r;
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    p_r;
  logic [PC_W-1:0]     pr_r, pc_r, pkr_r, pkc_r;
  logic [T_W-1:0]      y_r, x_r;
  logic [Q_W-1:0]      q_r;
  logic [D_W-1:0]      di_r, dj_r;
  logic [NPAT_MAX-1:0] alive_r;
  logic [CNT_W-1:0]    ncnt_r;
  logic [7:0]          win_r [TT];
  logic                em_r, cf_r;
  logic [SC_W-1:0]     scan_r;
  logic [CR_W-1:0]     sr_r, bestr_r;
  logic [CC_W-1:0]     sc_r, bestc_r;
  logic [CNT_W-1:0]    best_r;
  logic                found_r;
  logic                out_valid_r;
  logic                done_o_r;
  logic [7:0]          pix_o_r, cnt_o_r;
  logic [4:0]          row_o_r, col_o_r;

  logic                in_acc;
  logic [NR_W-1:0]     ni_f;
  logic [NC_W-1:0]     nj_f;
  logic                nb_in;
  logic [CR_W-1:0]     ni;
  logic [CC_W-1:0]     nj;
  logic                nb_last, nb_step;
  logic [D_W-1:0]      ndi, ndj;
  logic [T_W-1:0]      ny, nx;
  logic                yx_last;
  logic [PC_W-1:0]     npr, npc;
  logic [OA_W-1:0]     oaddr;
  logic                out_we;
  logic [OA_W-1:0]     out_waddr, out_raddr;
  logic [7:0]          out_wdata, out_rdata;
  logic                snap_we;
  logic [BA_W-1:0]     snap_raddr;
  logic [7:0]          snap_rdata;
  logic                base_we;
  logic [7:0]          base_rdata;
  logic                cell_we;
  logic [CA_W-1:0]     cell_waddr, cell_raddr;
  cell_t               cell_wdata, cell_rdata;
  logic [NPAT_MAX-1:0] mask;
  logic [7:0]          wv;
  logic                em_c, cf_c, supd;
  logic                mod_start, mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic [PC_W-1:0]     pcols_c, prows_c;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign ni_f    = NR_W'(cr_r) + NR_W'(di_r);
  assign nj_f    = NC_W'(cc_r) + NC_W'(dj_r);
  assign nb_in   = (int'(ni_f) >= TILE - 1) && (int'(ni_f) < OUT_H + TILE - 1) &&
                   (int'(nj_f) >= TILE - 1) && (int'(nj_f) < OUT_W + TILE - 1);
  assign ni      = CR_W'(ni_f - NR_W'(TILE - 1));
  assign nj      = CC_W'(nj_f - NC_W'(TILE - 1));
  assign nb_last = (di_r == D_W'(2 * TILE - 2)) && (dj_r == D_W'(2 * TILE - 2));
  assign nb_step = (state_r == S_NSEL && !nb_in) ||
                   (state_r == S_NRD && !cell_rdata.live) || (state_r == S_NWB);

  always_comb begin
    ndi = di_r;
    ndj = dj_r + 1'b1;
    if (dj_r == D_W'(2 * TILE - 2)) begin
      ndj = '0;
      ndi = di_r + 1'b1;
    end
    ny = y_r;
    nx = x_r + 1'b1;
    if (x_r == T_W'(TILE - 1)) begin
      nx = '0;
      ny = (y_r == T_W'(TILE - 1)) ? '0 : T_W'(y_r + 1'b1);
    end
    npr = pr_r;
    npc = pc_r + 1'b1;
    if (pc_r == pcols_r - 1'b1) begin
      npc = '0;
      npr = pr_r + 1'b1;
    end
  end

  assign yx_last = (y_r == T_W'(TILE - 1)) && (x_r == T_W'(TILE - 1));
  assign pcols_c = pat_side(bw_r);
  assign prows_c = pat_side(bh_r);

  always_comb begin
    for (int p = 0; p < NPAT_MAX; p++) begin
      mask[p] = (p < int'(ptot_r));
    end
  end

  // output map ports
  always_comb begin
    if (state_r == S_WISS || state_r == S_WEVAL) begin
      oaddr = out_addr(int'(cr_r) + int'(y_r), int'(cc_r) + int'(x_r));
    end else begin
      oaddr = out_addr(int'(ni) + int'(y_r), int'(nj) + int'(x_r));
    end
    out_raddr = (state_r == S_IDLE) ? out_addr(int'(in_row), int'(in_col)) : oaddr;
    out_we    = (state_r == S_CLR && int'(idx_r) < OUT_NPIX) ||
                (state_r == S_WEVAL && out_rdata == 8'd0);
    out_waddr = (state_r == S_CLR) ? OA_W'(idx_r) : oaddr;
    out_wdata = (state_r == S_CLR) ? 8'd0 : snap_rdata;
  end

  // base map and its snapshot
  assign base_we    = in_acc && in_mode == MODE_LOAD &&
                      int'(in_row) < BASE_MAX && int'(in_col) < BASE_MAX;
  assign snap_we    = state_r == S_CLR && start_r && idx_r != '0 && int'(idx_r) <= BASE_N;
  assign snap_raddr = (state_r == S_WISS) ?
                      base_addr(int'(pkr_r) + int'(y_r), int'(pkc_r) + int'(x_r)) :
                      base_addr(int'(pr_r) + int'(y_r), int'(pc_r) + int'(x_r));

  // cell rows
  always_comb begin
    case (state_r)
      S_CRD:   cell_raddr = cell_addr(int'(cr_r), int'(cc_r));
      S_NSEL:  cell_raddr = cell_addr(int'(ni), int'(nj));
      default: cell_raddr = CA_W'(scan_r);
    endcase
    cell_we    = (state_r == S_CLR && int'(idx_r) < NCELL) || (state_r == S_NWB);
    cell_waddr = (state_r == S_CLR) ? CA_W'(idx_r) : cell_addr(int'(ni), int'(nj));
    if (state_r == S_CLR) begin
      cell_wdata = '{live: 1'b1, cnt: ptot_r, alive: mask};
    end else begin
      cell_wdata = '{live: (ncnt_r != '0), cnt: ncnt_r, alive: alive_r};
    end
  end

  assign wv   = win_r[WI_W'(q_r - 1'b1)];
  assign em_c = (q_r != '0) && (em_r || wv == 8'd0);
  assign cf_c = (q_r != '0) && (cf_r || (wv != 8'd0 && wv != snap_rdata));
  assign supd = (scan_r != '0) && cell_rdata.live && (!found_r || cell_rdata.cnt < best_r);

  assign mod_start = (state_r == S_CCHK) && cell_rdata.live && (cell_rdata.cnt != '0);

  wct_ram #(.WIDTH(8), .DEPTH(BASE_N)) u_base (
    .clk(clk), .we(base_we), .waddr(base_addr(int'(in_row), int'(in_col))),
    .wdata(in_pixel), .raddr(BA_W'(idx_r)), .rdata(base_rdata)
  );

  wct_ram #(.WIDTH(8), .DEPTH(BASE_N)) u_snap (
    .clk(clk), .we(snap_we), .waddr(BA_W'(idx_r - 1'b1)),
    .wdata(base_rdata), .raddr(snap_raddr), .rdata(snap_rdata)
  );

  wct_ram #(.WIDTH(8), .DEPTH(OUT_NPIX)) u_out (
    .clk(clk), .we(out_we), .waddr(out_waddr),
    .wdata(out_wdata), .raddr(out_raddr), .rdata(out_rdata)
  );

  wct_ram #(.WIDTH($bits(cell_t)), .DEPTH(NCELL)) u_cell (
    .clk(clk), .we(cell_we), .waddr(cell_waddr),
    .wdata(cell_wdata), .raddr(cell_raddr), .rdata(cell_rdata)
  );

  wct_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(rnd_r),
    .divisor(cell_rdata.cnt), .done(mod_done), .rem(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      start_r     <= 1'b0;
      fin_r       <= 1'b1;
      cr_r        <= '0;
      cc_r        <= '0;
      cnt_r       <= '0;
      bw_r        <= DIM_W'(16);
      bh_r        <= DIM_W'(16);
      pcols_r     <= PC_W'(1);
      ptot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  bw_r <= cfg_data;
          CFG_HEIGHT: bh_r <= cfg_data;
          default:    ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == IDX_W'(CLR_LEN - 1)) begin
            start_r <= 1'b0;
            if (start_r) begin
              cr_r    <= '0;
              cc_r    <= '0;
              cnt_r   <= ptot_r;
              fin_r   <= 1'b0;
              state_r <= S_RESP;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            pix_r <= 8'd0;
            rnd_r <= in_random;
            case (in_mode)
              MODE_LOAD: state_r <= S_RESP;
              MODE_START: begin
                pcols_r <= pcols_c;
                ptot_r  <= CNT_W'(int'(pcols_c) * int'(prows_c));
                idx_r   <= '0;
                start_r <= 1'b1;
                state_r <= S_CLR;
              end
              MODE_STEP: state_r <= fin_r ? S_RESP : S_CRD;
              MODE_READ: begin
                if (int'(in_row) < RES_H && int'(in_col) < RES_W) begin
                  state_r <= S_RD;
                end else begin
                  state_r <= S_RESP;
                end
              end
              default: state_r <= S_RESP;
            endcase
          end
        end
        S_RD: begin
          pix_r   <= out_rdata;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            done_o_r    <= fin_r;
            pix_o_r     <= pix_r;
            row_o_r     <= fin_r ? 5'd0 : 5'(cr_r);
            col_o_r     <= fin_r ? 5'd0 : 5'(cc_r);
            if (fin_r) begin
              cnt_o_r <= 8'd0;
            end else if (int'(cnt_r) > 255) begin
              cnt_o_r <= 8'd255;
            end else begin
              cnt_o_r <= 8'(cnt_r);
            end
            state_r <= S_IDLE;
          end
        end
        S_CRD: state_r <= S_CCHK;
        S_CCHK: begin
          alive_r <= cell_rdata.alive;
          if (mod_start) begin
            state_r <= S_CDIV;
          end else begin
            di_r    <= '0;
            dj_r    <= '0;
            state_r <= S_NSEL;
          end
        end
        S_CDIV: begin
          if (mod_done) begin
            k_r     <= mod_rem;
            p_r     <= '0;
            pr_r    <= '0;
            pc_r    <= '0;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (p_r == ptot_r) begin
            di_r    <= '0;
            dj_r    <= '0;
            state_r <= S_NSEL;
          end else if (alive_r[p_r] && k_r == '0) begin
            pkr_r   <= pr_r;
            pkc_r   <= pc_r;
            y_r     <= '0;
            x_r     <= '0;
            state_r <= S_WISS;
          end else begin
            if (alive_r[p_r]) k_r <= k_r - 1'b1;
            p_r  <= p_r + 1'b1;
            pr_r <= npr;
            pc_r <= npc;
          end
        end
        S_WISS: state_r <= S_WEVAL;
        S_WEVAL: begin
          y_r <= ny;
          x_r <= nx;
          if (yx_last) begin
            di_r    <= '0;
            dj_r    <= '0;
            state_r <= S_NSEL;
          end else begin
            state_r <= S_WISS;
          end
        end
        S_NSEL: begin
          if (nb_in) state_r <= S_NRD;
        end
        S_NRD: begin
          if (cell_rdata.live) begin
            alive_r <= cell_rdata.alive;
            ncnt_r  <= cell_rdata.cnt;
            q_r     <= '0;
            y_r     <= '0;
            x_r     <= '0;
            state_r <= S_NWIN;
          end
        end
        S_NWIN: begin
          if (q_r != '0) win_r[WI_W'(q_r - 1'b1)] <= out_rdata;
          if (q_r == Q_W'(TT)) begin
            q_r     <= '0;
            p_r     <= '0;
            pr_r    <= '0;
            pc_r    <= '0;
            state_r <= S_NPAT;
          end else begin
            q_r <= q_r + 1'b1;
            y_r <= ny;
            x_r <= nx;
          end
        end
        S_NPAT: begin
          if (p_r == ptot_r) begin
            state_r <= S_NWB;
          end else if (!alive_r[p_r]) begin
            p_r  <= p_r + 1'b1;
            pr_r <= npr;
            pc_r <= npc;
          end else begin
            em_r <= em_c;
            cf_r <= cf_c;
            if (q_r == Q_W'(TT)) begin
              if (!em_c || cf_c) begin
                alive_r[p_r] <= 1'b0;
                ncnt_r       <= ncnt_r - 1'b1;
              end
              q_r  <= '0;
              p_r  <= p_r + 1'b1;
              pr_r <= npr;
              pc_r <= npc;
            end else begin
              q_r <= q_r + 1'b1;
              y_r <= ny;
              x_r <= nx;
            end
          end
        end
        S_NWB: ;
        S_SRCH: begin
          scan_r <= scan_r + 1'b1;
          if (supd) begin
            found_r <= 1'b1;
            best_r  <= cell_rdata.cnt;
            bestr_r <= sr_r;
            bestc_r <= sc_r;
          end
          if (scan_r != '0) begin
            if (sc_r == CC_W'(OUT_W - 1)) begin
              sc_r <= '0;
              sr_r <= sr_r + 1'b1;
            end else begin
              sc_r <= sc_r + 1'b1;
            end
          end
          if (scan_r == SC_W'(NCELL)) begin
            if (supd) begin
              cr_r  <= sr_r;
              cc_r  <= sc_r;
              cnt_r <= cell_rdata.cnt;
            end else if (found_r) begin
              cr_r  <= bestr_r;
              cc_r  <= bestc_r;
              cnt_r <= best_r;
            end else begin
              fin_r <= 1'b1;
            end
            state_r <= S_RESP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (nb_step) begin
        if (nb_last) begin
          scan_r  <= '0;
          found_r <= 1'b0;
          sr_r    <= '0;
          sc_r    <= '0;
          state_r <= S_SRCH;
        end else begin
          di_r    <= ndi;
          dj_r    <= ndj;
          state_r <= S_NSEL;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_done_res   = done_o_r;
  assign out_pixel_out  = pix_o_r;
  assign out_cell_row   = row_o_r;
  assign out_cell_col   = col_o_r;
  assign out_live_count = cnt_o_r;

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("item presented without passing the response state");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_o_r |-> row_o_r == 5'd0 && col_o_r == 5'd0 && cnt_o_r == 8'd0)
    else $error("finished item carries a cell");

  a_pat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NPAT || state_r == S_PICK) |-> p_r <= ptot_r)
    else $error("pattern index past pattern total");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !cell_we && !snap_we)
    else $error("cell or snapshot write while idle");

endmodule
